>>> rtl/http_request_header_tokenizer_macros.svh
// Assertion macros for the HTTP request header tokenizer checker.
// Needs signals named clock and reset in the scope of each use.
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_MACROS_SVH

// same-cycle implication
`define HRHT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HRHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/hrht_pkg.sv
// Types, constants and helpers for the HTTP request header tokenizer.
// No dependencies.
package hrht_pkg;

   localparam int LENGTH_BITS = 16;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   localparam logic [2:0] GET_LEN    = 3'd3;
   localparam logic [2:0] HOST_LEN   = 3'd4;
   localparam logic [2:0] NO_MATCH   = 3'd7;

   typedef enum logic [2:0] {
      PH_METHOD   = 3'd0,
      PH_RESOURCE = 3'd1,
      PH_PROTOCOL = 3'd2,
      PH_NAME     = 3'd3,
      PH_VALUE    = 3'd4,
      PH_BODY     = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      K_METHOD   = 3'd0,
      K_RESOURCE = 3'd1,
      K_PROTOCOL = 3'd2,
      K_NAME     = 3'd3,
      K_VALUE    = 3'd4,
      K_DROP     = 3'd5,
      K_BODY     = 3'd6
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_request;
   } req_type;

   typedef struct packed {
      kind_type    field_kind;
      logic [7:0]  out_byte;
      logic        field_end;
      logic        host_value;
      logic        method_get;
      logic        headers_done;
      logic [15:0] header_length;
   } rsp_type;

   function automatic logic [7:0] get_char(input logic [1:0] idx);
      case (idx)
         2'd0:    get_char = 8'h47; // G
         2'd1:    get_char = 8'h45; // E
         default: get_char = 8'h54; // T
      endcase
   endfunction

   function automatic logic [7:0] host_char(input logic [1:0] idx);
      case (idx)
         2'd0:    host_char = 8'h68; // h
         2'd1:    host_char = 8'h6F; // o
         2'd2:    host_char = 8'h73; // s
         default: host_char = 8'h74; // t
      endcase
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) to_lower = c + 8'h20;
      else to_lower = c;
   endfunction

endpackage

>>> rtl/http_request_header_tokenizer.sv
// Top level of the HTTP request header tokenizer: input register, per-byte
// parse logic, result register. Depends on hrht_pkg.
//
//   channel | ports                        | payload
//   --------+------------------------------+----------------------
//   request | req_valid, req_stall, req_data | hrht_pkg::req_type
//   result  | rsp_valid, rsp_stall, rsp_data | hrht_pkg::rsp_type
//
// One word per cycle sustained while rsp_stall is low; a word's result reaches
// rsp_data through the input register, then the result register.
// The parse state is updated as a word moves from the input register into
// the result register, so consecutive bytes chain through one short step.
// A stall on the result side backs up into req_stall only once both
// registers hold a word. Reset is synchronous and clears both valids and
// the parse state.
module http_request_header_tokenizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  hrht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output hrht_pkg::rsp_type rsp_data
);

   logic                               in_valid_ff, in_valid_in;
   hrht_pkg::req_type                  in_data_ff;
   logic                               rsp_valid_ff, rsp_valid_in;
   hrht_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   hrht_pkg::phase_type                phase_ff, phase_in;
   logic [2:0]                         method_match_ff, method_match_in;
   logic [2:0]                         name_match_ff, name_match_in;
   logic                               name_empty_ff, name_empty_in;
   logic                               skip_space_ff, skip_space_in;
   logic                               is_host_ff, is_host_in;
   logic                               is_get_ff, is_get_in;
   logic [hrht_pkg::LENGTH_BITS-1:0]   byte_count_ff, byte_count_in;

   logic                               req_accept;
   logic                               out_move;
   logic [7:0]                         b;
   logic [7:0]                         lower_b;

   assign out_move   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !out_move;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign b       = in_data_ff.data_byte;
   assign lower_b = hrht_pkg::to_lower(b);

   always_comb begin
      if (req_accept) in_valid_in = 1'b1;
      else if (out_move) in_valid_in = 1'b0;
      else in_valid_in = in_valid_ff;

      if (out_move) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // per-byte parse step
   always_comb begin
      if (in_data_ff.start_request) begin
         phase_in        = hrht_pkg::PH_METHOD;
         method_match_in = 3'd0;
         name_match_in   = 3'd0;
         name_empty_in   = 1'b1;
         skip_space_in   = 1'b0;
         is_host_in      = 1'b0;
         is_get_in       = 1'b0;
         byte_count_in   = '0;
      end else begin
         phase_in        = phase_ff;
         method_match_in = method_match_ff;
         name_match_in   = name_match_ff;
         name_empty_in   = name_empty_ff;
         skip_space_in   = skip_space_ff;
         is_host_in      = is_host_ff;
         is_get_in       = is_get_ff;
         byte_count_in   = byte_count_ff;
      end

      if (phase_in != hrht_pkg::PH_BODY && byte_count_in != '1)
         byte_count_in = byte_count_in + hrht_pkg::LENGTH_BITS'(1);

      rsp_data_in.field_kind = hrht_pkg::K_DROP;
      rsp_data_in.out_byte   = b;
      rsp_data_in.field_end  = 1'b0;
      rsp_data_in.host_value = 1'b0;

      if (phase_in == hrht_pkg::PH_BODY) begin
         rsp_data_in.field_kind = hrht_pkg::K_BODY;
      end else if (b == hrht_pkg::CHAR_CR) begin
         skip_space_in = 1'b0;
      end else begin
         case (phase_in)
            hrht_pkg::PH_METHOD: begin
               if (b == hrht_pkg::CHAR_SPACE) begin
                  rsp_data_in.field_end = 1'b1;
                  is_get_in = (method_match_in == hrht_pkg::GET_LEN);
                  phase_in  = hrht_pkg::PH_RESOURCE;
               end else begin
                  rsp_data_in.field_kind = hrht_pkg::K_METHOD;
                  if (method_match_in < hrht_pkg::GET_LEN &&
                      b == hrht_pkg::get_char(method_match_in[1:0]))
                     method_match_in = method_match_in + 3'd1;
                  else
                     method_match_in = hrht_pkg::NO_MATCH;
               end
            end
            hrht_pkg::PH_RESOURCE: begin
               if (b == hrht_pkg::CHAR_SPACE) begin
                  rsp_data_in.field_end = 1'b1;
                  phase_in = hrht_pkg::PH_PROTOCOL;
               end else begin
                  rsp_data_in.field_kind = hrht_pkg::K_RESOURCE;
               end
            end
            hrht_pkg::PH_PROTOCOL: begin
               if (b == hrht_pkg::CHAR_LF) begin
                  rsp_data_in.field_end = 1'b1;
                  phase_in      = hrht_pkg::PH_NAME;
                  name_empty_in = 1'b1;
                  name_match_in = 3'd0;
               end else begin
                  rsp_data_in.field_kind = hrht_pkg::K_PROTOCOL;
               end
            end
            hrht_pkg::PH_NAME: begin
               if (b == hrht_pkg::CHAR_LF) begin
                  // empty line ends the headers; otherwise drop the partial name
                  if (name_empty_in) begin
                     phase_in = hrht_pkg::PH_BODY;
                  end else begin
                     rsp_data_in.field_end = 1'b1;
                     name_empty_in = 1'b1;
                     name_match_in = 3'd0;
                  end
               end else if (b == hrht_pkg::CHAR_COLON) begin
                  rsp_data_in.field_end = 1'b1;
                  is_host_in    = (name_match_in == hrht_pkg::HOST_LEN);
                  skip_space_in = 1'b1;
                  phase_in      = hrht_pkg::PH_VALUE;
               end else begin
                  rsp_data_in.field_kind = hrht_pkg::K_NAME;
                  rsp_data_in.out_byte   = lower_b;
                  name_empty_in = 1'b0;
                  if (name_match_in < hrht_pkg::HOST_LEN &&
                      lower_b == hrht_pkg::host_char(name_match_in[1:0]))
                     name_match_in = name_match_in + 3'd1;
                  else
                     name_match_in = hrht_pkg::NO_MATCH;
               end
            end
            hrht_pkg::PH_VALUE: begin
               if (b == hrht_pkg::CHAR_LF) begin
                  rsp_data_in.field_end = 1'b1;
                  phase_in      = hrht_pkg::PH_NAME;
                  name_empty_in = 1'b1;
                  name_match_in = 3'd0;
                  is_host_in    = 1'b0;
                  skip_space_in = 1'b0;
               end else if (b == hrht_pkg::CHAR_SPACE && skip_space_in) begin
                  skip_space_in = 1'b0;
               end else begin
                  skip_space_in = 1'b0;
                  rsp_data_in.field_kind = hrht_pkg::K_VALUE;
                  rsp_data_in.host_value = is_host_in;
               end
            end
            default: begin
               phase_in = hrht_pkg::PH_BODY;
               rsp_data_in.field_kind = hrht_pkg::K_BODY;
            end
         endcase
      end

      rsp_data_in.method_get    = is_get_in;
      rsp_data_in.headers_done  = (phase_in == hrht_pkg::PH_BODY);
      rsp_data_in.header_length = 16'(byte_count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= hrht_pkg::PH_METHOD;
         method_match_ff <= 3'd0;
         name_match_ff   <= 3'd0;
         name_empty_ff   <= 1'b1;
         skip_space_ff   <= 1'b0;
         is_host_ff      <= 1'b0;
         is_get_ff       <= 1'b0;
         byte_count_ff   <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (out_move) begin
            phase_ff        <= phase_in;
            method_match_ff <= method_match_in;
            name_match_ff   <= name_match_in;
            name_empty_ff   <= name_empty_in;
            skip_space_ff   <= skip_space_in;
            is_host_ff      <= is_host_in;
            is_get_ff       <= is_get_in;
            byte_count_ff   <= byte_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) in_data_ff <= req_data;
      if (out_move) rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> rtl/hrht_checker.sv
// Port-level checker for the HTTP request header tokenizer, bound to the top.
// Depends on hrht_pkg and http_request_header_tokenizer_macros.svh.
`include "http_request_header_tokenizer_macros.svh"

module hrht_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hrht_pkg::rsp_type rsp_data
);

   `HRHT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data), "result word changed while stalled")

   // input only backs up when a finished word waits on the result side
   `HRHT_ASSERT_NOW(a_stall_full, req_stall, rsp_valid && rsp_stall,
      "input stalled with result side free")

   `HRHT_ASSERT_NOW(a_end_drop, rsp_valid && rsp_data.field_end,
      rsp_data.field_kind == hrht_pkg::K_DROP, "field end on a kept byte")

   `HRHT_ASSERT_NOW(a_host_kind, rsp_valid && rsp_data.host_value,
      rsp_data.field_kind == hrht_pkg::K_VALUE, "host flag outside a header value")

   `HRHT_ASSERT_NOW(a_done_kind, rsp_valid && rsp_data.headers_done,
      rsp_data.field_kind == hrht_pkg::K_BODY || rsp_data.field_kind == hrht_pkg::K_DROP,
      "header byte after end of headers")

endmodule

bind http_request_header_tokenizer hrht_checker u_hrht_checker (.*);

>>> bench/header_token_checker.sv
// Scoreboard for the HTTP request header tokenizer: tracks the parse state per
// accepted request word, queues the expected result words and compares them
// field by field with what leaves the result channel. Depends on hrht_pkg.
module header_token_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  hrht_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  hrht_pkg::rsp_type rsp_data,
   output int                errors,
   output int                outstanding,
   output int                checked,
   output int                host_hits
);

   localparam logic [23:0] GET_TEXT = "GET";
   localparam logic [31:0] HOST_TEXT = "host";
   localparam logic [hrht_pkg::LENGTH_BITS-1:0] LENGTH_CAP = '1;

   hrht_pkg::phase_type               phase;
   logic [2:0]                        method_prog;
   logic [2:0]                        name_prog;
   logic                              name_empty;
   logic                              skip_space;
   logic                              in_host;
   logic                              get_seen;
   logic [hrht_pkg::LENGTH_BITS-1:0]  length_count;
   hrht_pkg::rsp_type                 expected_q[$];

   task clear_parse();
      phase = hrht_pkg::PH_METHOD;
      method_prog = '0;
      name_prog = '0;
      name_empty = 1'b1;
      skip_space = 1'b0;
      in_host = 1'b0;
      get_seen = 1'b0;
      length_count = '0;
   endtask

   // advance the parse state by one byte and build the result word it yields
   task tokenize(input hrht_pkg::req_type w, output hrht_pkg::rsp_type r);
      logic [7:0]         b;
      logic [7:0]         ob;
      hrht_pkg::kind_type kind;
      logic               fend;
      logic               hval;
      b = w.data_byte;
      ob = b;
      kind = hrht_pkg::K_DROP;
      fend = 1'b0;
      hval = 1'b0;
      if (w.start_request) clear_parse();
      if (phase != hrht_pkg::PH_BODY && length_count != LENGTH_CAP) length_count++;
      if (phase == hrht_pkg::PH_BODY) begin
         kind = hrht_pkg::K_BODY;
      end else if (b == hrht_pkg::CHAR_CR) begin
         skip_space = 1'b0;
      end else begin
         case (phase)
            hrht_pkg::PH_METHOD: begin
               if (b == hrht_pkg::CHAR_SPACE) begin
                  fend = 1'b1;
                  get_seen = (method_prog == hrht_pkg::GET_LEN);
                  phase = hrht_pkg::PH_RESOURCE;
               end else begin
                  kind = hrht_pkg::K_METHOD;
                  if (method_prog < hrht_pkg::GET_LEN &&
                      b == GET_TEXT[8*(2-method_prog) +: 8])
                     method_prog++;
                  else
                     method_prog = hrht_pkg::NO_MATCH;
               end
            end
            hrht_pkg::PH_RESOURCE: begin
               if (b == hrht_pkg::CHAR_SPACE) begin
                  fend = 1'b1;
                  phase = hrht_pkg::PH_PROTOCOL;
               end else begin
                  kind = hrht_pkg::K_RESOURCE;
               end
            end
            hrht_pkg::PH_PROTOCOL: begin
               if (b == hrht_pkg::CHAR_LF) begin
                  fend = 1'b1;
                  phase = hrht_pkg::PH_NAME;
                  name_empty = 1'b1;
                  name_prog = '0;
               end else begin
                  kind = hrht_pkg::K_PROTOCOL;
               end
            end
            hrht_pkg::PH_NAME: begin
               if (b == hrht_pkg::CHAR_LF) begin
                  // LF with no name bytes is the blank line; otherwise the partial name is dropped
                  if (name_empty) begin
                     phase = hrht_pkg::PH_BODY;
                  end else begin
                     fend = 1'b1;
                     name_empty = 1'b1;
                     name_prog = '0;
                  end
               end else if (b == hrht_pkg::CHAR_COLON) begin
                  fend = 1'b1;
                  in_host = (name_prog == hrht_pkg::HOST_LEN);
                  skip_space = 1'b1;
                  phase = hrht_pkg::PH_VALUE;
               end else begin
                  kind = hrht_pkg::K_NAME;
                  ob = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
                  name_empty = 1'b0;
                  if (name_prog < hrht_pkg::HOST_LEN &&
                      ob == HOST_TEXT[8*(3-name_prog) +: 8])
                     name_prog++;
                  else
                     name_prog = hrht_pkg::NO_MATCH;
               end
            end
            hrht_pkg::PH_VALUE: begin
               if (b == hrht_pkg::CHAR_LF) begin
                  fend = 1'b1;
                  phase = hrht_pkg::PH_NAME;
                  name_empty = 1'b1;
                  name_prog = '0;
                  in_host = 1'b0;
                  skip_space = 1'b0;
               end else if (b == hrht_pkg::CHAR_SPACE && skip_space) begin
                  skip_space = 1'b0;
               end else begin
                  skip_space = 1'b0;
                  kind = hrht_pkg::K_VALUE;
                  hval = in_host;
               end
            end
            default: begin
               phase = hrht_pkg::PH_BODY;
               kind = hrht_pkg::K_BODY;
            end
         endcase
      end
      r.field_kind = kind;
      r.out_byte = ob;
      r.field_end = fend;
      r.host_value = hval;
      r.method_get = get_seen;
      r.headers_done = (phase == hrht_pkg::PH_BODY);
      r.header_length = length_count;
   endtask

   task compare_field(input string label, input logic [15:0] want, input logic [15:0] got);
      if (want !== got) begin
         if (errors < 10)
            $display("result %0d: %s expected %0h, got %0h", checked, label, want, got);
         errors++;
      end
   endtask

   initial begin
      errors = 0;
      checked = 0;
      host_hits = 0;
      outstanding = 0;
      clear_parse();
   end

   always @(posedge clock) begin
      hrht_pkg::rsp_type want;
      hrht_pkg::rsp_type got;
      if (reset) begin
         clear_parse();
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_q.size() == 0) begin
               if (errors < 10) $display("result word %h arrived with nothing expected", got);
               errors++;
            end else begin
               want = expected_q.pop_front();
               compare_field("field_kind", want.field_kind, got.field_kind);
               compare_field("out_byte", want.out_byte, got.out_byte);
               compare_field("field_end", want.field_end, got.field_end);
               compare_field("host_value", want.host_value, got.host_value);
               compare_field("method_get", want.method_get, got.method_get);
               compare_field("headers_done", want.headers_done, got.headers_done);
               compare_field("header_length", want.header_length, got.header_length);
               if (want.host_value) host_hits++;
               checked++;
            end
         end
         if (req_valid && !req_stall) begin
            tokenize(req_data, want);
            expected_q = {expected_q, want};
         end
      end
      outstanding <= expected_q.size();
   end

endmodule

>>> bench/testbench.sv
// Top of the tokenizer bench: clock, reset, request stimulus and result-side
// stalls; the verdict comes from header_token_checker. Depends on hrht_pkg
// and the http_request_header_tokenizer RTL.
module testbench;

   localparam int IDLE_PCT      = 31;
   localparam int RANDOM_BYTES  = 1300;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int DRAIN_CYCLES  = 8;

   typedef enum int {CS_TOKEN, CS_PRINT, CS_ANY} charset_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   hrht_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   hrht_pkg::rsp_type rsp_data;

   int         idle_pct;
   int         errors;
   int         outstanding;
   int         checked;
   int         host_hits;
   int         cycles;
   int         requests;
   int         bytes_sent;
   int         restart_at;
   logic       lead_start;
   logic [7:0] msg[$];

   http_request_header_tokenizer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   header_token_checker token_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .errors      (errors),
      .outstanding (outstanding),
      .checked     (checked),
      .host_hits   (host_hits)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < idle_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected", cycles, outstanding);
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [7:0] pick_char(charset_type cs);
      case (cs)
         CS_TOKEN: begin
            case ($urandom_range(3))
               0:       return 8'($urandom_range("z", "a"));
               1:       return 8'($urandom_range("Z", "A"));
               2:       return 8'($urandom_range("9", "0"));
               default: return "-";
            endcase
         end
         CS_PRINT: return 8'($urandom_range(126, 33));
         default: begin
            // lean on the delimiters so raw noise still hits the parser's branches
            case ($urandom_range(7))
               0:       return hrht_pkg::CHAR_CR;
               1:       return hrht_pkg::CHAR_LF;
               2:       return hrht_pkg::CHAR_COLON;
               3:       return hrht_pkg::CHAR_SPACE;
               default: return 8'($urandom_range(255));
            endcase
         end
      endcase
   endfunction

   task append_byte(input logic [7:0] b);
      msg = {msg, b};
   endtask

   task add_text(input string s);
      for (int i = 0; i < s.len(); i++) append_byte(s[i]);
   endtask

   task add_chars(input int n, input charset_type cs);
      repeat (n) append_byte(pick_char(cs));
   endtask

   task maybe_cr();
      if ($urandom_range(9) == 0) append_byte(hrht_pkg::CHAR_CR);
   endtask

   task line_end();
      if ($urandom_range(4) != 0) append_byte(hrht_pkg::CHAR_CR);
      append_byte(hrht_pkg::CHAR_LF);
   endtask

   // entered and left at a falling edge; valid stays up across back-to-back words
   task send_word(input logic [7:0] b, input logic st);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{data_byte: b, start_request: st};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task send_message();
      for (int i = 0; i < msg.size(); i++)
         send_word(msg[i], (i == 0 && lead_start) || i == restart_at);
      requests++;
   endtask

   // mostly well-formed requests with random content; some noise and broken ones
   task build_request();
      msg.delete();
      lead_start = ($urandom_range(19) != 0);
      restart_at = -1;
      if ($urandom_range(9) == 0) begin
         add_chars($urandom_range(30, 1), CS_ANY);
      end else begin
         case ($urandom_range(9))
            0, 1, 2, 3, 4: add_text("GET");
            5:             add_text("POST");
            6:             add_text("GE");
            7:             add_text("GETS");
            8:             ;  // empty method
            default:       add_chars($urandom_range(6, 1), CS_TOKEN);
         endcase
         maybe_cr();
         add_text(" /");
         add_chars($urandom_range(8), CS_TOKEN);
         maybe_cr();
         add_text(" HTTP/1.1");
         line_end();
         repeat ($urandom_range(4)) begin
            case ($urandom_range(9))
               0:       add_text("Host");
               1:       add_text("HOST");
               2:       add_text("host");
               3:       add_text("hOsT");
               4:       add_text("hos");
               5:       add_text("hosts");
               6:       add_text("Accept");
               7:       add_chars($urandom_range(4, 1), CS_ANY);
               default: add_chars($urandom_range(8, 1), CS_TOKEN);
            endcase
            maybe_cr();
            if ($urandom_range(9) == 0) begin
               line_end();  // name with no colon
            end else begin
               add_text(":");
               case ($urandom_range(3))
                  0:       ;
                  3:       add_text("  ");
                  default: add_text(" ");
               endcase
               add_chars($urandom_range(10), CS_PRINT);
               maybe_cr();
               line_end();
            end
         end
         if ($urandom_range(6) != 0) line_end();
         add_chars($urandom_range(6), CS_ANY);
      end
      if (msg.size() > 2 && $urandom_range(19) == 0)
         restart_at = $urandom_range(msg.size() - 1, 1);
   endtask

   initial begin
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      reset = 1'b1;
      idle_pct = IDLE_PCT;
      cycles = 0;
      requests = 0;
      bytes_sent = 0;
      lead_start = 1'b1;
      restart_at = -1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // GET, CR in protocol and name phases, host value 0xFF, bare name, blank line, body 0x00
      msg.delete();
      add_text("GET / H");
      append_byte(hrht_pkg::CHAR_CR);
      append_byte(hrht_pkg::CHAR_LF);
      add_text("Host: ");
      append_byte(8'hFF);
      append_byte(hrht_pkg::CHAR_CR);
      append_byte(hrht_pkg::CHAR_LF);
      add_text("x");
      append_byte(hrht_pkg::CHAR_LF);
      append_byte(hrht_pkg::CHAR_CR);
      append_byte(hrht_pkg::CHAR_LF);
      append_byte(8'h00);
      send_message();
      // CR in method, empty method, empty resource and protocol, empty name, value without space
      msg.delete();
      append_byte(hrht_pkg::CHAR_CR);
      add_text("  ");
      append_byte(hrht_pkg::CHAR_LF);
      add_text(":a");
      append_byte(hrht_pkg::CHAR_LF);
      send_message();

      while (bytes_sent < RANDOM_BYTES + 30) begin
         idle_pct = (bytes_sent > 400 && bytes_sent < 700) ? 0 : IDLE_PCT;
         build_request();
         send_message();
      end
      idle_pct = IDLE_PCT;

      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests in %0d bytes, mixing well-formed, broken and restarted ones",
               requests, bytes_sent);
      $display("%0d result words compared, %0d flagged as host value", checked, host_hits);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

>>> http_request_header_tokenizer.f
+incdir+rtl
rtl/hrht_pkg.sv
rtl/http_request_header_tokenizer.sv
rtl/hrht_checker.sv
bench/header_token_checker.sv
bench/testbench.sv
